@@ rtl/clipped_rect_fill_walker_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the clipped rectangle fill walker
// Each macro expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_RECT_FILL_WALKER_MACROS_SVH
`define CLIPPED_RECT_FILL_WALKER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CFRW_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("cfrw assertion failed");

`define CFRW_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfrw assertion failed");

`define CFRW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfrw assertion failed");

`else

`define CFRW_ASSERT_ALWAYS(label, cond)
`define CFRW_ASSERT_IMPL(label, ante, cons)
`define CFRW_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/cfrw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfrw_pkg
// Types, constants and helpers shared by the fill walker modules.
// ----------------------------------------------------------------------------
package cfrw_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int COORD_W   = $clog2(MAX_DIM + 1);
    localparam int OFFSET_W  = 26;
    localparam int PITCH_W   = 15;
    localparam int DIM_W     = 13;
    localparam int BYTES_W   = 3;
    localparam int COLOR_W   = 32;
    localparam int SUM_W     = (COORD_W + PITCH_W + 1 > OFFSET_W) ?
                               COORD_W + PITCH_W + 1 : OFFSET_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_FB_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FB_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES = 2'd3;

    typedef struct packed {
        logic                func;
        logic signed [15:0]  rect_x;
        logic signed [15:0]  rect_y;
        logic [15:0]         extent_x;
        logic [15:0]         extent_y;
        logic [COLOR_W-1:0]  fill_color;
    } in_item_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] byte_offset;
        logic [COLOR_W-1:0]  pixel_value;
        logic [BYTES_W-1:0]  byte_count;
        logic                last_pixel;
    } out_item_t;

    typedef struct packed {
        logic [DIM_W-1:0]   fb_width;
        logic [DIM_W-1:0]   fb_height;
        logic [PITCH_W-1:0] row_pitch;
        logic [BYTES_W-1:0] pixel_bytes;
    } cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] color;
        logic               last;
    } job_t;

    function automatic logic [BYTES_W-1:0] eff_bytes(input logic [BYTES_W-1:0] pb);
        logic [BYTES_W-1:0] r;
        if (pb == 3'd0)
            r = 3'd1;
        else if (pb > 3'd4)
            r = 3'd4;
        else
            r = pb;
        return r;
    endfunction

    function automatic logic [COLOR_W-1:0] keep_bytes(input logic [COLOR_W-1:0] c,
                                                      input logic [BYTES_W-1:0] nb);
        logic [COLOR_W-1:0] r;
        r = '0;
        for (int b = 0; b < COLOR_W / 8; b++)
        begin
            if (BYTES_W'(b) < nb)
                r[8*b +: 8] = c[8*b +: 8];
        end
        return r;
    endfunction

endpackage

@@ rtl/cfrw_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfrw_front
// Accepts transactions, clips start rectangles and walks the cursor, pushing
// one pixel job per tick while a rectangle is active.
// ----------------------------------------------------------------------------
`include "clipped_rect_fill_walker_macros.svh"

module cfrw_front
    import cfrw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    input  cfg_t     cfg,
    output logic     push,
    output job_t     push_job,
    input  logic     q_full
);

    logic               busy_reg, busy_next;
    logic [COORD_W-1:0] cursor_x_reg, cursor_x_next;
    logic [COORD_W-1:0] cursor_y_reg, cursor_y_next;
    logic [COORD_W-1:0] clip_left_reg, clip_left_next;
    logic [COORD_W-1:0] clip_right_reg, clip_right_next;
    logic [COORD_W-1:0] clip_bottom_reg, clip_bottom_next;
    logic [COLOR_W-1:0] color_reg, color_next;

    logic               accept;
    logic               is_start;
    logic [15:0]        lim_w, lim_h;
    logic signed [17:0] w_s, h_s;
    logic signed [17:0] left_s, top_s, right_s, bottom_s;
    logic signed [17:0] left_c, top_c, right_c, bottom_c;
    logic               empty;
    logic [COORD_W-1:0] x_inc, y_inc;
    logic               last;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign is_start = (in_data.func == FUNC_START);

    assign lim_w = ({3'b0, cfg.fb_width} > 16'(MAX_DIM)) ? 16'(MAX_DIM)
                                                         : {3'b0, cfg.fb_width};
    assign lim_h = ({3'b0, cfg.fb_height} > 16'(MAX_DIM)) ? 16'(MAX_DIM)
                                                          : {3'b0, cfg.fb_height};
    assign w_s = signed'({2'b0, lim_w});
    assign h_s = signed'({2'b0, lim_h});

    assign left_s   = 18'(in_data.rect_x);
    assign top_s    = 18'(in_data.rect_y);
    assign right_s  = left_s + signed'({2'b0, in_data.extent_x});
    assign bottom_s = top_s + signed'({2'b0, in_data.extent_y});

    assign left_c   = (left_s < 18'sd0) ? 18'sd0 : left_s;
    assign top_c    = (top_s < 18'sd0) ? 18'sd0 : top_s;
    assign right_c  = (right_s > w_s) ? w_s : right_s;
    assign bottom_c = (bottom_s > h_s) ? h_s : bottom_s;

    assign empty = (in_data.extent_x == 16'd0) || (in_data.extent_y == 16'd0)
                || (right_s <= 18'sd0) || (bottom_s <= 18'sd0)
                || (left_s >= w_s) || (top_s >= h_s)
                || (left_c >= right_c) || (top_c >= bottom_c);

    assign x_inc = cursor_x_reg + COORD_W'(1);
    assign y_inc = cursor_y_reg + COORD_W'(1);
    assign last  = (x_inc == clip_right_reg) && (y_inc == clip_bottom_reg);

    assign push           = accept && !is_start && busy_reg;
    assign push_job.x     = cursor_x_reg;
    assign push_job.y     = cursor_y_reg;
    assign push_job.color = color_reg;
    assign push_job.last  = last;

    always_comb
    begin
        busy_next        = busy_reg;
        cursor_x_next    = cursor_x_reg;
        cursor_y_next    = cursor_y_reg;
        clip_left_next   = clip_left_reg;
        clip_right_next  = clip_right_reg;
        clip_bottom_next = clip_bottom_reg;
        color_next       = color_reg;
        if (accept && is_start)
        begin
            busy_next = !empty;
            if (!empty)
            begin
                clip_left_next   = left_c[COORD_W-1:0];
                clip_right_next  = right_c[COORD_W-1:0];
                clip_bottom_next = bottom_c[COORD_W-1:0];
                cursor_x_next    = left_c[COORD_W-1:0];
                cursor_y_next    = top_c[COORD_W-1:0];
                color_next       = in_data.fill_color;
            end
        end
        else if (push)
        begin
            if (last)
            begin
                busy_next = 1'b0;
            end
            else if (x_inc >= clip_right_reg)
            begin
                cursor_x_next = clip_left_reg;
                cursor_y_next = y_inc;
            end
            else
            begin
                cursor_x_next = x_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            cursor_x_reg    <= '0;
            cursor_y_reg    <= '0;
            clip_left_reg   <= '0;
            clip_right_reg  <= '0;
            clip_bottom_reg <= '0;
            color_reg       <= '0;
        end
        else
        begin
            busy_reg        <= busy_next;
            cursor_x_reg    <= cursor_x_next;
            cursor_y_reg    <= cursor_y_next;
            clip_left_reg   <= clip_left_next;
            clip_right_reg  <= clip_right_next;
            clip_bottom_reg <= clip_bottom_next;
            color_reg       <= color_next;
        end
    end

    `CFRW_ASSERT_IMPL(a_cursor_in_clip, busy_reg,
        (cursor_x_reg < clip_right_reg) && (cursor_y_reg < clip_bottom_reg))
    `CFRW_ASSERT_NEXT(a_last_goes_idle, push && last, !busy_reg)
    `CFRW_ASSERT_IMPL(a_no_push_when_full, push, !q_full)

endmodule

@@ rtl/cfrw_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfrw_fifo
// Two-entry job queue between the front and back ends.
// ----------------------------------------------------------------------------
`include "clipped_rect_fill_walker_macros.svh"

module cfrw_fifo
    import cfrw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    job_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_job   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    `CFRW_ASSERT_ALWAYS(a_count_bound, count_reg <= 2'd2)
    `CFRW_ASSERT_IMPL(a_pop_needs_data, pop, head_valid)

endmodule

@@ rtl/cfrw_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfrw_back
// Turns pixel jobs into writes: multiply stage, then offset add into the
// output register.
// ----------------------------------------------------------------------------
module cfrw_back
    import cfrw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      head_valid,
    input  job_t      head_job,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic                         a_valid_reg, a_valid_next;
    logic [COORD_W+PITCH_W-1:0]   a_prod_y_reg;
    logic [COORD_W+BYTES_W-1:0]   a_prod_x_reg;
    logic [COLOR_W-1:0]           a_value_reg;
    logic [BYTES_W-1:0]           a_count_reg;
    logic                         a_last_reg;
    logic                         o_valid_reg, o_valid_next;
    out_item_t                    o_data_reg;

    logic                         a_ready, b_ready;
    logic [BYTES_W-1:0]           nb;
    logic [SUM_W-1:0]             sum;

    assign nb      = eff_bytes(cfg.pixel_bytes);
    assign b_ready = !o_valid_reg || out_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign pop     = head_valid && a_ready;

    assign sum = SUM_W'(a_prod_y_reg) + SUM_W'(a_prod_x_reg);

    assign a_valid_next = pop || (a_valid_reg && !b_ready);
    assign o_valid_next = (a_valid_reg && b_ready) || (o_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_prod_y_reg <= (COORD_W+PITCH_W)'(head_job.y)
                          * (COORD_W+PITCH_W)'(cfg.row_pitch);
            a_prod_x_reg <= (COORD_W+BYTES_W)'(head_job.x)
                          * (COORD_W+BYTES_W)'(nb);
            a_value_reg  <= keep_bytes(head_job.color, nb);
            a_count_reg  <= nb;
            a_last_reg   <= head_job.last;
        end
        if (a_valid_reg && b_ready)
        begin
            o_data_reg.byte_offset <= sum[OFFSET_W-1:0];
            o_data_reg.pixel_value <= a_value_reg;
            o_data_reg.byte_count  <= a_count_reg;
            o_data_reg.last_pixel  <= a_last_reg;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_data  = o_data_reg;

endmodule

@@ rtl/clipped_rect_fill_walker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_rect_fill_walker
// Rectangle fill engine with framebuffer clipping.
// ----------------------------------------------------------------------------
// A start transaction (func 0) clips the rectangle to the framebuffer and
// arms the walker; each tick transaction (func 1) then yields one pixel write
// in row-major order, the final one flagged last_pixel. Starts, and ticks
// while idle, produce no output. Input and output run at one transaction per
// clock while the queue has room and out_ready is high: the front end steps
// the cursor per accepted tick and the back end computes the offset in two
// pipeline stages (multiply, then add), joined by a two-entry queue. Write
// registers only while no transactions are in flight.
// ----------------------------------------------------------------------------
module clipped_rect_fill_walker
    import cfrw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    cfg_t cfg_reg, cfg_next;
    logic push, pop, q_full, head_valid;
    job_t push_job, head_job;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FB_WIDTH:    cfg_next.fb_width    = cfg_data[DIM_W-1:0];
                REG_FB_HEIGHT:   cfg_next.fb_height   = cfg_data[DIM_W-1:0];
                REG_ROW_PITCH:   cfg_next.row_pitch   = cfg_data[PITCH_W-1:0];
                REG_PIXEL_BYTES: cfg_next.pixel_bytes = cfg_data[BYTES_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fb_width    <= DIM_W'(640);
            cfg_reg.fb_height   <= DIM_W'(480);
            cfg_reg.row_pitch   <= PITCH_W'(2560);
            cfg_reg.pixel_bytes <= BYTES_W'(4);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    cfrw_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .cfg      (cfg_reg),
        .push     (push),
        .push_job (push_job),
        .q_full   (q_full)
    );

    cfrw_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    cfrw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule
